// ----- rtl/dmvmp_pkg.sv -----
// Package: command codes and field widths of the dual mode video memory port.
`default_nettype none
package dmvmp_pkg;

    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 17;
    localparam int S_DATA_W = 4 * BYTE_W;
    localparam int M_DATA_W = 2 * BYTE_W;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [IDX_W-1:0]    idx_t;

    localparam action_t ACT_NOP   = 3'd0;
    localparam action_t ACT_WRITE = 3'd1;
    localparam action_t ACT_READ  = 3'd2;
    localparam action_t ACT_PIXEL = 3'd3;
    localparam action_t ACT_TEXT  = 3'd4;

endpackage
`default_nettype wire

// ----- rtl/dmvmp_store.sv -----
// Single-port-write, registered-read memory used for the pixel and text stores.
`default_nettype none
module dmvmp_store
    import dmvmp_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int WIDTH = 16,
    parameter int AW    = 9
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/dual_mode_video_memory_port_top.sv -----
// Top level: command stream in, read words out, pixel and text stores.
// Read path: a read word passes through the registered store read, then the output
// register, before it is presented.
// Throughput: one command per cycle while the output is not stalled.
// Reset: synchronous, active low; the mode returns to text and a clearing pass over
// addresses 0 to max(SCREEN_WIDTH*SCREEN_HEIGHT, TEXT_COLUMNS*TEXT_ROWS)-1 zeroes both
// stores with s_tready low.
`default_nettype none
module dual_mode_video_memory_port_top
    import dmvmp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64,
    parameter int TEXT_COLUMNS  = 32,
    parameter int TEXT_ROWS     = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // pos_x, pos_y, data_lo, data_hi
    input  wire logic [ACTION_W-1:0] s_tuser,  // action
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata   // read_lo, read_hi
);

    localparam int PIX_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int TXT_SIZE = TEXT_COLUMNS * TEXT_ROWS;
    localparam int PIX_AW   = (PIX_SIZE > 1) ? $clog2(PIX_SIZE) : 1;
    localparam int TXT_AW   = (TXT_SIZE > 1) ? $clog2(TXT_SIZE) : 1;
    localparam int CLR_LEN  = (PIX_SIZE > TXT_SIZE) ? PIX_SIZE : TXT_SIZE;
    localparam int CLR_W    = $clog2(CLR_LEN + 1);

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    logic             state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             pixel_mode_reg, pixel_mode_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             pend_hit_reg;
    logic             pend_pix_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;

    action_t action;
    byte_t   pos_x, pos_y, data_lo, data_hi;
    idx_t    pix_idx, txt_idx;
    logic    pix_hit, txt_hit, hit;
    logic    accept, out_can_load, load;
    logic    is_read, is_write;

    logic              pix_we, txt_we;
    logic [PIX_AW-1:0] pix_addr;
    logic [TXT_AW-1:0] txt_addr;
    byte_t             pix_wdata;
    logic [2*BYTE_W-1:0] txt_wdata;
    byte_t             pix_rdata;
    logic [2*BYTE_W-1:0] txt_rdata;
    logic [M_DATA_W-1:0] out_word;

    assign action  = s_tuser;
    assign pos_x   = s_tdata[BYTE_W-1:0];
    assign pos_y   = s_tdata[2*BYTE_W-1:BYTE_W];
    assign data_lo = s_tdata[3*BYTE_W-1:2*BYTE_W];
    assign data_hi = s_tdata[4*BYTE_W-1:3*BYTE_W];

    assign pix_idx = IDX_W'(pos_x) + IDX_W'(pos_y) * IDX_W'(SCREEN_WIDTH);
    assign txt_idx = IDX_W'(pos_x) + IDX_W'(pos_y) * IDX_W'(TEXT_COLUMNS);
    assign pix_hit = pix_idx < IDX_W'(PIX_SIZE);
    assign txt_hit = txt_idx < IDX_W'(TXT_SIZE);
    assign hit     = pixel_mode_reg ? pix_hit : txt_hit;

    assign out_can_load = !m_tvalid_reg || m_tready;
    assign load         = rd_pend_reg && out_can_load;
    assign s_tready     = (state_reg == ST_RUN) && (!rd_pend_reg || out_can_load);
    assign accept       = s_tvalid && s_tready;
    assign is_read      = accept && (action == ACT_READ);
    assign is_write     = accept && (action == ACT_WRITE);

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            pix_we    = clr_cnt_reg < CLR_W'(PIX_SIZE);
            txt_we    = clr_cnt_reg < CLR_W'(TXT_SIZE);
            pix_addr  = clr_cnt_reg[PIX_AW-1:0];
            txt_addr  = clr_cnt_reg[TXT_AW-1:0];
            pix_wdata = '0;
            txt_wdata = '0;
        end else begin
            pix_we    = is_write && pixel_mode_reg && pix_hit;
            txt_we    = is_write && !pixel_mode_reg && txt_hit;
            pix_addr  = pix_idx[PIX_AW-1:0];
            txt_addr  = txt_idx[TXT_AW-1:0];
            pix_wdata = data_lo;
            txt_wdata = {data_hi, data_lo};
        end
    end

    dmvmp_store #(
        .DEPTH(PIX_SIZE),
        .WIDTH(BYTE_W),
        .AW   (PIX_AW)
    ) u_pix_store (
        .aclk     (aclk),
        .we       (pix_we),
        .waddr    (pix_addr),
        .wdata    (pix_wdata),
        .re       (is_read),
        .raddr    (pix_addr),
        .rdata_reg(pix_rdata)
    );

    dmvmp_store #(
        .DEPTH(TXT_SIZE),
        .WIDTH(2 * BYTE_W),
        .AW   (TXT_AW)
    ) u_txt_store (
        .aclk     (aclk),
        .we       (txt_we),
        .waddr    (txt_addr),
        .wdata    (txt_wdata),
        .re       (is_read),
        .raddr    (txt_addr),
        .rdata_reg(txt_rdata)
    );

    always_comb begin
        if (!pend_hit_reg) begin
            out_word = '0;
        end else if (pend_pix_reg) begin
            out_word = {byte_t'(0), pix_rdata};
        end else begin
            out_word = txt_rdata;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        if (state_reg == ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + CLR_W'(1);
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1)) begin
                state_next = ST_RUN;
            end
        end

        pixel_mode_next = pixel_mode_reg;
        if (accept && (action == ACT_PIXEL)) begin
            pixel_mode_next = 1'b1;
        end else if (accept && (action == ACT_TEXT)) begin
            pixel_mode_next = 1'b0;
        end

        if (is_read) begin
            rd_pend_next = 1'b1;
        end else if (load) begin
            rd_pend_next = 1'b0;
        end else begin
            rd_pend_next = rd_pend_reg;
        end

        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            pixel_mode_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pixel_mode_reg <= pixel_mode_next;
            rd_pend_reg    <= rd_pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (is_read) begin
            pend_hit_reg <= hit;
            pend_pix_reg <= pixel_mode_reg;
        end
        if (load) begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // no commands taken while the stores are being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("command accepted during clearing pass");

    // an accepted read leaves a pending read behind
    a_read_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        is_read |=> rd_pend_reg)
        else $error("accepted read not pending");

    // a pending read that cannot move out is held
    a_pend_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_pend_reg && !out_can_load) |=> (rd_pend_reg && m_tvalid_reg))
        else $error("pending read lost while output stalled");

    // out-of-range read returns zeros
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !pend_hit_reg) |=> (m_tdata_reg == '0))
        else $error("out-of-range read returned nonzero word");

    // pixel-mode read has a zero high byte
    a_pix_hi_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && pend_pix_reg) |=> (m_tdata_reg[M_DATA_W-1:BYTE_W] == '0))
        else $error("pixel-mode read returned nonzero high byte");

endmodule
`default_nettype wire
